>>> hw/rtl/tsl_skin_pixel_classifier_macros.svh
// Assertion helpers for the skin pixel classifier.
`ifndef TSL_SKIN_PIXEL_CLASSIFIER_MACROS_SVH
`define TSL_SKIN_PIXEL_CLASSIFIER_MACROS_SVH
`ifndef SYNTHESIS
`define TSL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define TSL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`else
`define TSL_ASSERT(lbl, prop, msg)
`define TSL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> hw/rtl/tsl_pkg.sv
package tsl_pkg;

  localparam int unsigned ChanW = 8;
  localparam int unsigned SumW  = 10;
  localparam int unsigned HueW  = 9;
  localparam int unsigned LimW  = 16;
  localparam int unsigned AngW  = 32;
  localparam int unsigned TW    = 19;
  localparam int unsigned RootW = 32;
  localparam int unsigned RadW  = 64;
  localparam int unsigned SqrtStages = 32;

  typedef enum logic [1:0] {
    CFG_HUE_LOW   = 2'd0,
    CFG_HUE_HIGH  = 2'd1,
    CFG_NEAR_ZERO = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic zero;
    logic neg;
    logic nz;
  } ctag_t;

  function automatic logic [AngW-1:0] atan_turn(input int unsigned idx);
    logic [AngW-1:0] v;
    case (idx)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/tsl_skin_pixel_classifier.sv
// Skin pixel classifier.
// Drive one RGB pixel on red_i/green_i/blue_i with start high; the pixel is
// taken at that clock edge. busy stays low, so a pixel may be offered every
// cycle. For each pixel taken, out_valid_o is high for one cycle with
// skin_flag_o set when the pixel falls in the skin region. Results leave in
// the order pixels came in, one per pixel.
// The latency is set by the path through the bit-per-stage divider
// (FRACTION_BITS + 1 stages) and the 32-stage square root pipeline; the tint
// CORDIC (CORDIC_STAGES stages) runs beside the root and is delayed to match.
// Throughput is one pixel per cycle.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i (0 hue_low,
// 1 hue_high, 2 near_zero_limit) and cfg_data_i; cfg_ready_o is always high.
// Write the registers only with no pixel in flight.
// Reset clears the pipeline valid bits and loads 125, 185 and 66.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "tsl_skin_pixel_classifier_macros.svh"
module tsl_skin_pixel_classifier import tsl_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 16,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [ChanW-1:0] red_i,
  input  logic [ChanW-1:0] green_i,
  input  logic [ChanW-1:0] blue_i,
  output logic             out_valid_o,
  output logic             skin_flag_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [LimW-1:0]  cfg_data_i
);

  localparam int unsigned F    = FRACTION_BITS;
  localparam int unsigned RcW  = F + 2;
  localparam int unsigned CW   = F + 4;
  localparam int unsigned SqW  = 2 * F + 4;
  localparam int unsigned QW   = 2 * F + 1;
  localparam int unsigned DlyN = 33 - CORDIC_STAGES;
  localparam longint unsigned C33 = (33 * (64'd1 << F) + 50) / 100;
  localparam logic signed [RcW-1:0] C33S     = RcW'(C33);
  localparam logic signed [TW-1:0]  TBasePos = 19'sd19200;
  localparam logic signed [TW-1:0]  TBaseNeg = 19'sd57600;
  localparam int unsigned PW = 34;

  // configuration
  logic [HueW-1:0] hue_low_q, hue_low_d, hue_high_q, hue_high_d;
  logic [LimW-1:0] lim_q, lim_d;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_comb begin
    hue_low_d  = hue_low_q;
    hue_high_d = hue_high_q;
    lim_d      = lim_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_HUE_LOW:   hue_low_d  = cfg_data_i[HueW-1:0];
        CFG_HUE_HIGH:  hue_high_d = cfg_data_i[HueW-1:0];
        CFG_NEAR_ZERO: lim_d      = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_low_q  <= 9'd125;
      hue_high_q <= 9'd185;
      lim_q      <= 16'd66;
    end else begin
      hue_low_q  <= hue_low_d;
      hue_high_q <= hue_high_d;
      lim_q      <= lim_d;
    end
  end

  // input stage
  logic             in_vld_q, in_zero_q;
  logic [ChanW-1:0] in_red_q, in_green_q;
  logic [SumW-1:0]  in_sum_q, in_sum_d;

  assign in_sum_d = SumW'(red_i) + SumW'(green_i) + SumW'(blue_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    in_red_q   <= red_i;
    in_green_q <= green_i;
    in_sum_q   <= in_sum_d;
    in_zero_q  <= in_sum_d == '0;
  end

  // chromaticity division
  logic       d_vld, d_zero;
  logic [F:0] d_qa, d_qb;

  tsl_div #(.FracBits(F)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_vld_q),
    .num_a_i (in_red_q),
    .num_b_i (in_green_q),
    .den_i   (in_sum_q),
    .zero_i  (in_zero_q),
    .valid_o (d_vld),
    .quo_a_o (d_qa),
    .quo_b_o (d_qb),
    .zero_o  (d_zero)
  );

  // offset, sign fold, near-zero test
  logic signed [RcW-1:0] rc_d, gc_d, ag_d, y_d;
  logic [F+15:0]         lim_ext;
  logic [F-1:0]          eps;
  ctag_t                 tag_d;

  assign rc_d    = $signed({1'b0, d_qa}) - C33S;
  assign gc_d    = $signed({1'b0, d_qb}) - C33S;
  assign ag_d    = gc_d[RcW-1] ? -gc_d : gc_d;
  assign y_d     = gc_d[RcW-1] ? -rc_d : rc_d;
  assign lim_ext = {lim_q, {F{1'b0}}};
  assign eps     = lim_ext[F+15:16];
  assign tag_d   = '{zero: d_zero, neg: gc_d[RcW-1], nz: $unsigned(ag_d) < {2'b00, eps}};

  logic                  p_vld_q;
  logic signed [CW-1:0]  p_x_q, p_y_q;
  logic signed [RcW-1:0] p_rc_q, p_gc_q;
  ctag_t                 p_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else begin
      p_vld_q <= d_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    p_x_q   <= CW'(ag_d);
    p_y_q   <= CW'(y_d);
    p_rc_q  <= rc_d;
    p_gc_q  <= gc_d;
    p_tag_q <= tag_d;
  end

  // tint path
  logic                   c_vld;
  logic signed [AngW-1:0] c_z;
  ctag_t                  c_tag;

  tsl_cordic #(.FracBits(F), .Stages(CORDIC_STAGES)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p_vld_q),
    .x_i     (p_x_q),
    .y_i     (p_y_q),
    .tag_i   (p_tag_q),
    .valid_o (c_vld),
    .z_o     (c_z),
    .tag_o   (c_tag)
  );

  logic [AngW-1:0] zabs;
  logic            ta_vld_q, ta_zneg_q;
  logic [48:0]     ta_prod_q, ta_rnd;
  ctag_t           ta_tag_q;

  assign zabs = c_z[AngW-1] ? AngW'(-c_z) : AngW'(c_z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ta_vld_q <= 1'b0;
    end else begin
      ta_vld_q <= c_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    ta_prod_q <= 49'(zabs) * 49'd76800;
    ta_zneg_q <= c_z[AngW-1];
    ta_tag_q  <= c_tag;
  end

  logic signed [TW-1:0] t8_d, base, magv;

  assign ta_rnd = ta_prod_q + 49'd2147483648;
  assign magv   = $signed({2'b00, ta_rnd[48:32]});
  assign base   = ta_tag_q.neg ? TBaseNeg : TBasePos;
  assign t8_d   = ta_tag_q.nz ? '0 : (ta_zneg_q ? base - magv : base + magv);

  logic                 dl_vld_q  [DlyN+1];
  logic                 dl_zero_q [DlyN+1];
  logic signed [TW-1:0] dl_t8_q   [DlyN+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= DlyN; i++) begin
        dl_vld_q[i] <= 1'b0;
      end
    end else begin
      dl_vld_q[0] <= ta_vld_q;
      for (int i = 1; i <= DlyN; i++) begin
        dl_vld_q[i] <= dl_vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dl_t8_q[0]   <= t8_d;
    dl_zero_q[0] <= ta_tag_q.zero;
    for (int i = 1; i <= DlyN; i++) begin
      dl_t8_q[i]   <= dl_t8_q[i-1];
      dl_zero_q[i] <= dl_zero_q[i-1];
    end
  end

  // saturation path
  logic                  sa_vld_q, sb_vld_q, sc_vld_q;
  logic signed [SqW-1:0] sqa, sqb;
  logic [2*F-1:0]        sa_a_q, sa_b_q;
  logic [QW-1:0]         qsum;
  logic [QW+31:0]        qw;
  logic [31:0]           sb_q32_q;
  logic [RadW-1:0]       sc_rad_q;

  assign sqa  = SqW'(p_rc_q) * SqW'(p_rc_q);
  assign sqb  = SqW'(p_gc_q) * SqW'(p_gc_q);
  assign qsum = {1'b0, sa_a_q} + {1'b0, sa_b_q};
  assign qw   = {qsum, 32'h0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_vld_q <= 1'b0;
      sb_vld_q <= 1'b0;
      sc_vld_q <= 1'b0;
    end else begin
      sa_vld_q <= p_vld_q;
      sb_vld_q <= sa_vld_q;
      sc_vld_q <= sb_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sa_a_q   <= sqa[2*F-1:0];
    sa_b_q   <= sqb[2*F-1:0];
    sb_q32_q <= qw[2*F+31:2*F];
    sc_rad_q <= RadW'(sb_q32_q) * 64'd1179648000;
  end

  logic             s_vld;
  logic [RootW-1:0] s_root;

  tsl_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sc_vld_q),
    .rad_i   (sc_rad_q),
    .valid_o (s_vld),
    .root_o  (s_root)
  );

  // line tests
  logic                 t_vld, t_zero;
  logic signed [TW-1:0] t_t8;

  assign t_vld  = dl_vld_q[DlyN];
  assign t_zero = dl_zero_q[DlyN];
  assign t_t8   = dl_t8_q[DlyN];

  logic                 f_vld_q, f_zero_q;
  logic signed [TW-1:0] f_t8_q;
  logic signed [PW-1:0] f_p1_q, f_p2_q, f_ps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else begin
      f_vld_q <= s_vld && t_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    f_zero_q <= t_zero;
    f_t8_q   <= t_t8;
    f_p1_q   <= PW'(t_t8) * 34'sd10330;
    f_p2_q   <= PW'(t_t8) * 34'sd19670;
    f_ps_q   <= $signed(PW'(s_root[RootW-1:16])) * 34'sd10000;
  end

  logic cond;
  logic out_vld_q, skin_q;

  assign cond = (f_t8_q > $signed({2'b00, hue_low_q, 8'h00})) &&
                (f_t8_q < $signed({2'b00, hue_high_q, 8'h00})) &&
                ((f_p1_q - 34'sd293996800) > f_ps_q) &&
                ((34'sd973203200 - f_p2_q) > f_ps_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      skin_q    <= 1'b0;
    end else begin
      out_vld_q <= f_vld_q;
      skin_q    <= f_vld_q && !f_zero_q && cond;
    end
  end

  assign out_valid_o = out_vld_q;
  assign skin_flag_o = skin_q;

  `TSL_ASSERT(path_align, t_vld == s_vld, "tint and saturation paths out of step")
  `TSL_ASSERT(skin_window, skin_flag_o |-> $past(hue_high_q > hue_low_q), "skin outside hue window")
  `TSL_ASSERT_NEXT(final_valid, f_vld_q, out_valid_o, "result word dropped")

endmodule

>>> hw/rtl/tsl_div.sv
`include "tsl_skin_pixel_classifier_macros.svh"
module tsl_div import tsl_pkg::*; #(
  parameter int unsigned FracBits = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [ChanW-1:0]    num_a_i,
  input  logic [ChanW-1:0]    num_b_i,
  input  logic [SumW-1:0]     den_i,
  input  logic                zero_i,
  output logic                valid_o,
  output logic [FracBits:0]   quo_a_o,
  output logic [FracBits:0]   quo_b_o,
  output logic                zero_o
);

  localparam int unsigned Stages = FracBits + 1;

  logic                vld_q   [Stages];
  logic                zero_q  [Stages];
  logic [SumW-1:0]     den_q   [Stages];
  logic [SumW-1:0]     rem_a_q [Stages];
  logic [SumW-1:0]     rem_b_q [Stages];
  logic [FracBits:0]   quo_a_q [Stages];
  logic [FracBits:0]   quo_b_q [Stages];

  for (genvar s = 0; s < Stages; s++) begin : g_st
    logic [SumW:0]     par_a, par_b, dif_a, dif_b;
    logic [SumW-1:0]   den_in;
    logic [FracBits:0] qa_in, qb_in;
    logic              vin, zin, ba, bb;

    if (s == 0) begin : g_first
      assign par_a  = (SumW+1)'(num_a_i);
      assign par_b  = (SumW+1)'(num_b_i);
      assign den_in = den_i;
      assign qa_in  = '0;
      assign qb_in  = '0;
      assign vin    = valid_i;
      assign zin    = zero_i;
    end else begin : g_next
      assign par_a  = {rem_a_q[s-1], 1'b0};
      assign par_b  = {rem_b_q[s-1], 1'b0};
      assign den_in = den_q[s-1];
      assign qa_in  = quo_a_q[s-1];
      assign qb_in  = quo_b_q[s-1];
      assign vin    = vld_q[s-1];
      assign zin    = zero_q[s-1];
    end

    assign ba    = par_a >= {1'b0, den_in};
    assign bb    = par_b >= {1'b0, den_in};
    assign dif_a = par_a - {1'b0, den_in};
    assign dif_b = par_b - {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      den_q[s]   <= den_in;
      zero_q[s]  <= zin;
      rem_a_q[s] <= ba ? dif_a[SumW-1:0] : par_a[SumW-1:0];
      rem_b_q[s] <= bb ? dif_b[SumW-1:0] : par_b[SumW-1:0];
      quo_a_q[s] <= {qa_in[FracBits-1:0], ba};
      quo_b_q[s] <= {qb_in[FracBits-1:0], bb};
    end
  end

  assign valid_o = vld_q[Stages-1];
  assign quo_a_o = quo_a_q[Stages-1];
  assign quo_b_o = quo_b_q[Stages-1];
  assign zero_o  = zero_q[Stages-1];

  `TSL_ASSERT(div_rem_a, (valid_o && !zero_o) |-> (rem_a_q[Stages-1] < den_q[Stages-1]), "div remainder out of range")

endmodule

>>> hw/rtl/tsl_cordic.sv
`include "tsl_skin_pixel_classifier_macros.svh"
module tsl_cordic import tsl_pkg::*; #(
  parameter int unsigned FracBits = 16,
  parameter int unsigned Stages   = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic signed [FracBits+3:0] x_i,
  input  logic signed [FracBits+3:0] y_i,
  input  ctag_t                      tag_i,
  output logic                       valid_o,
  output logic signed [AngW-1:0]     z_o,
  output ctag_t                      tag_o
);

  localparam int unsigned CW = FracBits + 4;

  logic                   vld_q [Stages];
  logic signed [CW-1:0]   x_q   [Stages];
  logic signed [CW-1:0]   y_q   [Stages];
  logic signed [AngW-1:0] z_q   [Stages];
  ctag_t                  tag_q [Stages];

  for (genvar s = 0; s < Stages; s++) begin : g_st
    logic signed [CW-1:0]   xin, yin, xn, yn;
    logic signed [AngW-1:0] zin, zn;
    logic                   vin;
    ctag_t                  tin;

    if (s == 0) begin : g_first
      assign xin = x_i;
      assign yin = y_i;
      assign zin = '0;
      assign vin = valid_i;
      assign tin = tag_i;
    end else begin : g_next
      assign xin = x_q[s-1];
      assign yin = y_q[s-1];
      assign zin = z_q[s-1];
      assign vin = vld_q[s-1];
      assign tin = tag_q[s-1];
    end

    always_comb begin
      if (!yin[CW-1]) begin
        xn = xin + (yin >>> s);
        yn = yin - (xin >>> s);
        zn = zin + $signed(atan_turn(s));
      end else begin
        xn = xin - (yin >>> s);
        yn = yin + (xin >>> s);
        zn = zin - $signed(atan_turn(s));
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      x_q[s]   <= xn;
      z_q[s]   <= zn;
      tag_q[s] <= tin;
    end

    if (s < Stages - 1) begin : g_y
      always_ff @(posedge clk_i) begin
        y_q[s] <= yn;
      end
    end
  end

  assign valid_o = vld_q[Stages-1];
  assign z_o     = z_q[Stages-1];
  assign tag_o   = tag_q[Stages-1];

  `TSL_ASSERT(cordic_x_pos, valid_o |-> !x_q[Stages-1][CW-1], "cordic x went negative")

endmodule

>>> hw/rtl/tsl_sqrt.sv
`include "tsl_skin_pixel_classifier_macros.svh"
module tsl_sqrt import tsl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [RadW-1:0]  rad_i,
  output logic             valid_o,
  output logic [RootW-1:0] root_o
);

  localparam int unsigned RemW = RootW + 2;
  localparam int unsigned TW2  = RemW + 2;

  logic             vld_q  [SqrtStages];
  logic [RemW-1:0]  rem_q  [SqrtStages];
  logic [RootW-1:0] root_q [SqrtStages];
  logic [RadW-1:0]  rad_q  [SqrtStages-1];

  for (genvar s = 0; s < SqrtStages; s++) begin : g_st
    logic [RemW-1:0]  remin;
    logic [RootW-1:0] rootin;
    logic [RadW-1:0]  radin;
    logic [TW2-1:0]   tv, trial, dif;
    logic             vin, ge;

    if (s == 0) begin : g_first
      assign remin  = '0;
      assign rootin = '0;
      assign radin  = rad_i;
      assign vin    = valid_i;
    end else begin : g_next
      assign remin  = rem_q[s-1];
      assign rootin = root_q[s-1];
      assign radin  = rad_q[s-1];
      assign vin    = vld_q[s-1];
    end

    assign tv    = {remin, radin[RadW-1 -: 2]};
    assign trial = {2'b00, rootin, 2'b01};
    assign ge    = tv >= trial;
    assign dif   = tv - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= ge ? dif[RemW-1:0] : tv[RemW-1:0];
      root_q[s] <= {rootin[RootW-2:0], ge};
    end

    if (s < SqrtStages - 1) begin : g_rad
      always_ff @(posedge clk_i) begin
        rad_q[s] <= {radin[RadW-3:0], 2'b00};
      end
    end
  end

  assign valid_o = vld_q[SqrtStages-1];
  assign root_o  = root_q[SqrtStages-1];

  `TSL_ASSERT(sqrt_rem_bound, valid_o |-> (rem_q[SqrtStages-1] <= {1'b0, root_o, 1'b0}), "sqrt remainder too large")

endmodule

>>> sim/tsl_skin_pixel_classifier_tb.sv
module tsl_skin_pixel_classifier_tb import tsl_pkg::*; ();

  class skin_scoreboard;
    logic [HueW-1:0] hue_lo;
    logic [HueW-1:0] hue_hi;
    logic [LimW-1:0] zero_lim;
    bit              flags_due[$];
    longint          atan_tab[16];

    function new();
      hue_lo   = 9'd125;
      hue_hi   = 9'd185;
      zero_lim = 16'd66;
      atan_tab = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
                   64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
                   64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
                   64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned res;
      longint unsigned bt;
      res = 0;
      bt  = 64'd1 << 62;
      while (bt > v) bt = bt >> 2;
      while (bt != 0) begin
        if (v >= res + bt) begin
          v   = v - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
      return res;
    endfunction

    function bit classify(logic [ChanW-1:0] r, logic [ChanW-1:0] g, logic [ChanW-1:0] b);
      longint          sum, third, rc, gc, ag, x, y, z, dx, dy, mag, base, t8, s8;
      longint unsigned q;
      sum = longint'(r) + longint'(g) + longint'(b);
      if (sum == 0) return 1'b0;
      third = 21627;
      rc = ((longint'(r) << 16) / sum) - third;
      gc = ((longint'(g) << 16) / sum) - third;
      ag = (gc < 0) ? -gc : gc;
      if (ag < longint'(zero_lim)) begin
        t8 = 0;
      end else begin
        x    = ag;
        y    = (gc >= 0) ? rc : -rc;
        z    = 0;
        base = (gc >= 0) ? 75 * 256 : 225 * 256;
        for (int i = 0; i < 16; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (y >= 0) begin
            x = x + dx;
            y = y - dy;
            z = z + atan_tab[i];
          end else begin
            x = x - dx;
            y = y + dy;
            z = z - atan_tab[i];
          end
        end
        mag = (z < 0) ? -z : z;
        mag = longint'(($unsigned(mag) * 64'd76800 + (64'd1 << 31)) >> 32);
        t8  = (z < 0) ? base - mag : base + mag;
      end
      q  = $unsigned(rc * rc) + $unsigned(gc * gc);
      s8 = longint'(root(64'd1179648000 * q) >> 16);
      return (t8 > (longint'(hue_lo) << 8)) && (t8 < (longint'(hue_hi) << 8)) &&
             ((10330 * t8 - 293996800) > 10000 * s8) &&
             ((973203200 - 19670 * t8) > 10000 * s8);
    endfunction

    function void note_pixel(logic [ChanW-1:0] r, logic [ChanW-1:0] g, logic [ChanW-1:0] b);
      flags_due.push_back(classify(r, g, b));
    endfunction

    // 0 match, 1 mismatch, 2 nothing pending
    function int check_flag(bit got, output bit want);
      want = 1'b0;
      if (flags_due.size() == 0) return 2;
      want = flags_due.pop_front();
      return (want == got) ? 0 : 1;
    endfunction
  endclass

  localparam int FRACTION_BITS_DEF = 16;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [ChanW-1:0] red_i, green_i, blue_i;
  logic             out_valid_o;
  logic             skin_flag_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [1:0]       cfg_index_i;
  logic [LimW-1:0]  cfg_data_i;

  skin_scoreboard sb;
  int errors;
  int pixels_sent;
  int flags_seen;
  int skin_seen;
  int cfg_writes;

  tsl_skin_pixel_classifier dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .out_valid_o (out_valid_o),
    .skin_flag_o (skin_flag_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  task automatic report(string what);
    errors++;
    $display("ERROR %0t: %s", $realtime, what);
  endtask

  always @(negedge clk_i) begin
    bit want;
    int st;
    if (rst_ni && out_valid_o) begin
      flags_seen++;
      if (skin_flag_o) skin_seen++;
      st = sb.check_flag(skin_flag_o, want);
      if (st == 2) report("skin flag word with nothing pending");
      else if (st == 1)
        report($sformatf("skin_flag got %0b want %0b", skin_flag_o, want));
    end
  end

  // called right after a rising edge
  task automatic idle_cycles(int n);
    repeat (n) @(posedge clk_i);
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(80, 10);
  endfunction

  task automatic send_pixel(logic [ChanW-1:0] r, logic [ChanW-1:0] g, logic [ChanW-1:0] b,
                            int gap);
    bit acc;
    start   <= 1'b1;
    red_i   <= r;
    green_i <= g;
    blue_i  <= b;
    do begin
      @(negedge clk_i);
      acc = !busy;
      @(posedge clk_i);
    end while (!acc);
    sb.note_pixel(r, g, b);
    pixels_sent++;
    if (gap > 0) begin
      start <= 1'b0;
      idle_cycles(gap);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.flags_due.size() != 0) @(posedge clk_i);
    idle_cycles(FRACTION_BITS_DEF + 8);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [LimW-1:0] val);
    bit acc;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do begin
      @(negedge clk_i);
      acc = cfg_ready_o;
      @(posedge clk_i);
    end while (!acc);
    cfg_valid_i <= 1'b0;
    cfg_writes++;
    case (idx)
      CFG_HUE_LOW:   sb.hue_lo   = val[HueW-1:0];
      CFG_HUE_HIGH:  sb.hue_hi   = val[HueW-1:0];
      CFG_NEAR_ZERO: sb.zero_lim = val;
      default: ;
    endcase
  endtask

  task automatic set_window(int lo, int hi, int lim);
    drain();
    write_reg(CFG_HUE_LOW, LimW'(lo));
    write_reg(CFG_HUE_HIGH, LimW'(hi));
    write_reg(CFG_NEAR_ZERO, LimW'(lim));
  endtask

  task automatic directed_pixels();
    send_pixel(8'd0, 8'd0, 8'd0, pick_gap());
    send_pixel(8'd255, 8'd255, 8'd255, pick_gap());
    send_pixel(8'd255, 8'd0, 8'd0, pick_gap());
    send_pixel(8'd0, 8'd255, 8'd0, pick_gap());
    send_pixel(8'd0, 8'd0, 8'd255, pick_gap());
    send_pixel(8'd1, 8'd0, 8'd0, pick_gap());
    send_pixel(8'd0, 8'd1, 8'd0, pick_gap());
    send_pixel(8'd0, 8'd0, 8'd1, pick_gap());
    send_pixel(8'd1, 8'd1, 8'd1, pick_gap());
    send_pixel(8'd200, 8'd120, 8'd90, pick_gap());
    send_pixel(8'd224, 8'd172, 8'd105, pick_gap());
    send_pixel(8'd160, 8'd100, 8'd70, pick_gap());
    send_pixel(8'd0, 8'd33, 8'd67, pick_gap());
    send_pixel(8'd67, 8'd33, 8'd0, pick_gap());
    send_pixel(8'd1, 8'd33, 8'd66, pick_gap());
    send_pixel(8'd100, 8'd67, 8'd36, pick_gap());
    send_pixel(8'd255, 8'd128, 8'd0, pick_gap());
    send_pixel(8'd128, 8'd255, 8'd128, pick_gap());
    send_pixel(8'd170, 8'd85, 8'd0, pick_gap());
    send_pixel(8'd85, 8'd85, 8'd85, 0);
  endtask

  task automatic random_pixels(int n);
    logic [ChanW-1:0] r, g, b;
    int mode;
    bit long_run;
    for (int i = 0; i < n; i++) begin
      mode = $urandom_range(9);
      if (mode < 4) begin
        r = ChanW'($urandom);
        g = ChanW'($urandom);
        b = ChanW'($urandom);
      end else if (mode < 8) begin
        r = ChanW'($urandom_range(255, 90));
        g = ChanW'($urandom_range(r, r / 3));
        b = ChanW'($urandom_range(g, 0));
      end else begin
        r = ChanW'($urandom_range(4));
        g = ChanW'($urandom_range(4));
        b = ChanW'($urandom_range(4));
      end
      if (i % 64 == 0) long_run = 1'($urandom_range(1));
      send_pixel(r, g, b, long_run ? 0 : pick_gap());
      if (i == n / 2 && $urandom_range(1)) drain();
    end
  endtask

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int wait_cnt;
    sb = new();
    errors = 0;
    pixels_sent = 0;
    flags_seen = 0;
    skin_seen = 0;
    cfg_writes = 0;
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    red_i       <= '0;
    green_i     <= '0;
    blue_i      <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_HUE_LOW;
    cfg_data_i  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    idle_cycles(2);

    directed_pixels();
    random_pixels(200);
    // hold until the pipe is empty
    drain();
    random_pixels(20);

    set_window(0, 300, 0);
    directed_pixels();
    random_pixels(150);
    set_window(511, 0, 65535);
    random_pixels(100);
    set_window(0, 511, 65535);
    random_pixels(100);
    set_window(0, 511, 0);
    directed_pixels();
    random_pixels(150);
    set_window(125, 185, 0);
    random_pixels(150);
    set_window(100, 200, 66);
    random_pixels(150);
    for (int k = 0; k < 3; k++) begin
      set_window($urandom_range(511), $urandom_range(511), $urandom_range(65535));
      random_pixels(80);
    end
    set_window($urandom_range(150, 80), $urandom_range(260, 160), $urandom_range(400));
    random_pixels(100);

    start <= 1'b0;
    wait_cnt = 0;
    while (sb.flags_due.size() != 0 && wait_cnt < 10000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    if (sb.flags_due.size() != 0)
      report($sformatf("%0d skin flags never arrived", sb.flags_due.size()));
    idle_cycles(80);

    $display("Covered %0d pixels, %0d flags checked (%0d skin), %0d register writes",
             pixels_sent, flags_seen, skin_seen, cfg_writes);
    $display("Windows: reset, full, empty, wide, zero limit, max limit, random; %0d errors",
             errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
